### src/krt_pkg.sv
`default_nettype none

package krt_pkg;

	// field widths
	localparam int KEY_W = 32;
	localparam int TAG_W = 64;
	localparam int AMT_W = 32;
	localparam int CNT_W = 7;
	// amount sum over a full table: 64 * (2^32 - 1) fits in 38 bits
	localparam int SUM_W = AMT_W + CNT_W - 1;
	localparam int OP_W = 3;
	localparam int IN_TDATA_W = KEY_W + TAG_W + AMT_W;
	localparam int OUT_TDATA_W = 136;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND  = 3'd0,
		OP_LIST    = 3'd1,
		OP_FIND    = 3'd2,
		OP_DELETE  = 3'd3,
		OP_AVERAGE = 3'd4
	} opcode_t;

	typedef enum logic [1:0] {
		STAT_DONE      = 2'd0,
		STAT_FULL      = 2'd1,
		STAT_NOT_FOUND = 2'd2,
		STAT_EMPTY     = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_APPEND,
		S_LIST_RD,
		S_LIST_OUT,
		S_SCAN,
		S_SHIFT,
		S_SUM,
		S_DIV,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic [TAG_W-1:0]        tag;
		logic [AMT_W-1:0]        amount;
	} rec_t;

	// result handed from the sequencer to the output register
	typedef struct packed {
		logic    valid;
		status_t status;
		rec_t    rec;
		logic    last;
	} emit_t;

endpackage

`default_nettype wire

### src/krt_mem.sv
`default_nettype none

module krt_mem #(
	parameter int DEPTH  = 64,
	parameter int ADDR_W = 6
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [ADDR_W-1:0]    waddr,
	input  wire krt_pkg::rec_t        wdata,
	input  wire logic [ADDR_W-1:0]    raddr,
	output krt_pkg::rec_t             rdata
);

	krt_pkg::rec_t mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### src/krt_div.sv
`default_nettype none

module krt_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [krt_pkg::SUM_W-1:0]   dividend,
	input  wire logic [krt_pkg::CNT_W-1:0]   divisor,
	output logic                             done,
	output logic [krt_pkg::SUM_W-1:0]        quotient
);

	localparam int STEP_W = $clog2(krt_pkg::SUM_W);

	logic                        busy_q;
	logic                        done_q;
	logic [STEP_W-1:0]           step_q;
	logic [krt_pkg::CNT_W-1:0]   rem_q;
	logic [krt_pkg::CNT_W-1:0]   dvs_q;
	logic [krt_pkg::SUM_W-1:0]   quo_q;
	logic [krt_pkg::CNT_W:0]     trial;
	logic                        ge;
	logic [krt_pkg::CNT_W:0]     diff;

	// restoring step: one quotient bit per cycle
	assign trial = {rem_q, quo_q[krt_pkg::SUM_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(krt_pkg::SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[krt_pkg::CNT_W-1:0] : trial[krt_pkg::CNT_W-1:0];
			quo_q <= {quo_q[krt_pkg::SUM_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

### src/krt_seq.sv
`default_nettype none

module krt_seq #(
	parameter int CAPACITY = 64,
	parameter int ADDR_W   = 6
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// input word
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [krt_pkg::OP_W-1:0]      in_op,
	input  wire krt_pkg::rec_t                 in_rec,
	// result toward the output register
	input  wire logic                          out_free,
	output krt_pkg::emit_t                     emit,
	output logic [krt_pkg::CNT_W-1:0]          fill,
	// record memory
	output logic                               mem_we,
	output logic [ADDR_W-1:0]                  mem_waddr,
	output krt_pkg::rec_t                      mem_wdata,
	output logic [ADDR_W-1:0]                  mem_raddr,
	input  wire krt_pkg::rec_t                 mem_rdata,
	// divider
	output logic                               div_start,
	output logic [krt_pkg::SUM_W-1:0]          div_dividend,
	output logic [krt_pkg::CNT_W-1:0]          div_divisor,
	input  wire logic                          div_done,
	input  wire logic [krt_pkg::SUM_W-1:0]     div_quot
);

	localparam logic [krt_pkg::CNT_W-1:0] CAP_C = krt_pkg::CNT_W'(CAPACITY);

	krt_pkg::state_t            state_q, state_d;
	logic [krt_pkg::CNT_W-1:0]  count_q;
	logic [krt_pkg::CNT_W-1:0]  idx_q;
	logic [krt_pkg::CNT_W-1:0]  pidx_q;
	logic                       pv_q;
	logic [krt_pkg::OP_W-1:0]   op_q;
	krt_pkg::rec_t              in_q;
	krt_pkg::rec_t              res_q;
	krt_pkg::status_t           status_q;
	logic [krt_pkg::SUM_W-1:0]  sum_q;

	logic [krt_pkg::CNT_W-1:0]  idx_nx;
	logic                       accept;
	logic                       full;
	logic                       match;
	logic                       scan_issue;
	logic                       shift_issue;
	logic                       walk_done;
	logic                       shift_done;

	// shared flags
	assign idx_nx      = idx_q + 1'b1;
	assign accept      = in_valid && in_ready;
	assign full        = count_q >= CAP_C;
	assign match       = pv_q && (mem_rdata.key == in_q.key);
	assign scan_issue  = idx_q < count_q;
	assign shift_issue = idx_nx < count_q;
	assign walk_done   = !scan_issue && !pv_q;
	assign shift_done  = !shift_issue && !pv_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			krt_pkg::S_IDLE: begin
				if (in_valid) begin
					unique case (in_op)
						krt_pkg::OP_APPEND:  state_d = krt_pkg::S_APPEND;
						krt_pkg::OP_LIST:    state_d = (count_q == '0) ? krt_pkg::S_EMIT
						                                               : krt_pkg::S_LIST_RD;
						krt_pkg::OP_FIND,
						krt_pkg::OP_DELETE:  state_d = krt_pkg::S_SCAN;
						krt_pkg::OP_AVERAGE: state_d = krt_pkg::S_SUM;
						default:             state_d = krt_pkg::S_EMIT;
					endcase
				end
			end
			krt_pkg::S_APPEND: state_d = krt_pkg::S_EMIT;
			krt_pkg::S_LIST_RD: state_d = krt_pkg::S_LIST_OUT;
			krt_pkg::S_LIST_OUT: begin
				if (out_free) begin
					state_d = (idx_nx == count_q) ? krt_pkg::S_IDLE : krt_pkg::S_LIST_RD;
				end
			end
			krt_pkg::S_SCAN: begin
				if (match) begin
					state_d = (op_q == krt_pkg::OP_FIND) ? krt_pkg::S_EMIT : krt_pkg::S_SHIFT;
				end else if (!scan_issue) begin
					state_d = krt_pkg::S_EMIT;
				end
			end
			krt_pkg::S_SHIFT: begin
				if (shift_done) begin
					state_d = krt_pkg::S_EMIT;
				end
			end
			krt_pkg::S_SUM: begin
				if (walk_done) begin
					state_d = (count_q == '0) ? krt_pkg::S_EMIT : krt_pkg::S_DIV;
				end
			end
			krt_pkg::S_DIV: begin
				if (div_done) begin
					state_d = krt_pkg::S_EMIT;
				end
			end
			krt_pkg::S_EMIT: begin
				if (out_free) begin
					state_d = krt_pkg::S_IDLE;
				end
			end
			default: state_d = krt_pkg::S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready     = (state_q == krt_pkg::S_IDLE);
		mem_we       = ((state_q == krt_pkg::S_APPEND) && !full)
		            || ((state_q == krt_pkg::S_SHIFT) && pv_q);
		mem_waddr    = (state_q == krt_pkg::S_APPEND) ? count_q[ADDR_W-1:0]
		                                              : pidx_q[ADDR_W-1:0];
		mem_wdata    = (state_q == krt_pkg::S_APPEND) ? in_q : mem_rdata;
		mem_raddr    = (state_q == krt_pkg::S_SHIFT) ? idx_nx[ADDR_W-1:0]
		                                             : idx_q[ADDR_W-1:0];
		div_start    = (state_q == krt_pkg::S_SUM) && walk_done && (count_q != '0);
		div_dividend = sum_q;
		div_divisor  = count_q;
		fill         = count_q;
		emit         = '0;
		unique case (state_q)
			krt_pkg::S_LIST_OUT: begin
				emit.valid  = 1'b1;
				emit.status = krt_pkg::STAT_DONE;
				emit.rec    = mem_rdata;
				emit.last   = (idx_nx == count_q);
			end
			krt_pkg::S_EMIT: begin
				emit.valid  = 1'b1;
				emit.status = status_q;
				emit.rec    = res_q;
				emit.last   = 1'b1;
			end
			default: emit = '0;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= krt_pkg::S_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			pv_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				krt_pkg::S_IDLE: begin
					if (accept) begin
						idx_q <= '0;
						pv_q  <= 1'b0;
					end
				end
				krt_pkg::S_APPEND: begin
					if (!full) begin
						count_q <= count_q + 1'b1;
					end
				end
				krt_pkg::S_LIST_OUT: begin
					if (out_free) begin
						idx_q <= idx_nx;
					end
				end
				krt_pkg::S_SCAN: begin
					if (match) begin
						idx_q <= pidx_q;
						pv_q  <= 1'b0;
					end else if (scan_issue) begin
						idx_q <= idx_nx;
						pv_q  <= 1'b1;
					end
				end
				krt_pkg::S_SHIFT: begin
					pv_q <= shift_issue;
					if (shift_issue) begin
						idx_q <= idx_nx;
					end
					if (shift_done) begin
						count_q <= count_q - 1'b1;
					end
				end
				krt_pkg::S_SUM: begin
					pv_q <= scan_issue;
					if (scan_issue) begin
						idx_q <= idx_nx;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			krt_pkg::S_IDLE: begin
				if (accept) begin
					op_q     <= in_op;
					in_q     <= in_rec;
					res_q    <= '0;
					sum_q    <= '0;
					status_q <= ((in_op == krt_pkg::OP_LIST) && (count_q == '0))
					          ? krt_pkg::STAT_EMPTY : krt_pkg::STAT_DONE;
				end
			end
			krt_pkg::S_APPEND: begin
				if (full) begin
					status_q <= krt_pkg::STAT_FULL;
				end else begin
					res_q <= in_q;
				end
			end
			krt_pkg::S_SCAN: begin
				if (match) begin
					res_q <= mem_rdata;
				end else if (!scan_issue) begin
					status_q <= krt_pkg::STAT_NOT_FOUND;
				end
				if (!match && scan_issue) begin
					pidx_q <= idx_q;
				end
			end
			krt_pkg::S_SHIFT: begin
				if (shift_issue) begin
					pidx_q <= idx_q;
				end
			end
			krt_pkg::S_SUM: begin
				if (pv_q) begin
					sum_q <= sum_q + krt_pkg::SUM_W'(mem_rdata.amount);
				end
			end
			krt_pkg::S_DIV: begin
				if (div_done) begin
					res_q.amount <= div_quot[krt_pkg::AMT_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

### src/keyed_record_table_top.sv
`default_nettype none

// Keyed record table: an unsorted, packed table of up to CAPACITY records
// (signed key, 64-bit name tag, amount in hundredths) held in one memory.
// Commands enter on the s_ stream: s_tuser is the opcode (append, list,
// find, delete, average), s_tdata carries key, tag and amount. Results
// leave on the m_ stream; m_tlast marks the final result of a command.
// One command is worked at a time; s_tready is high only while idle, and a
// command is taken even while the previous result still sits in the output
// register. Delete scans for the key, then shifts later records down one
// record per cycle; average sums the amounts, then divides by the count
// in the bit-serial divider, and on an empty table skips the divider.
// The single memory read port sets the walk rate of list, find, delete and
// the average sum. Reset empties the table at once; no clearing pass.
// A stall on m_tready holds the result and freezes the sequencer in its
// emit or list-output step until the word is taken.

module keyed_record_table_top #(
	parameter int CAPACITY = 64
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// record_key, name_tag, amount
	input  wire logic [krt_pkg::IN_TDATA_W-1:0]      s_tdata,
	// opcode
	input  wire logic [krt_pkg::OP_W-1:0]            s_tuser,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// out_key, out_name_tag, out_amount, fill_count, zero pad
	output logic [krt_pkg::OUT_TDATA_W-1:0]          m_tdata,
	// status
	output logic [1:0]                               m_tuser,
	output logic                                     m_tlast
);

	localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	krt_pkg::rec_t               in_rec;
	krt_pkg::emit_t              emit;
	logic [krt_pkg::CNT_W-1:0]   fill;
	logic                        out_free;
	logic                        mem_we;
	logic [ADDR_W-1:0]           mem_waddr;
	krt_pkg::rec_t               mem_wdata;
	logic [ADDR_W-1:0]           mem_raddr;
	krt_pkg::rec_t               mem_rdata;
	logic                        div_start;
	logic [krt_pkg::SUM_W-1:0]   div_dividend;
	logic [krt_pkg::CNT_W-1:0]   div_divisor;
	logic                        div_done;
	logic [krt_pkg::SUM_W-1:0]   div_quot;

	logic                        m_valid_q;
	krt_pkg::emit_t              out_q;
	logic [krt_pkg::CNT_W-1:0]   fill_q;

	// unpack input word
	assign in_rec.key    = s_tdata[krt_pkg::KEY_W-1:0];
	assign in_rec.tag    = s_tdata[krt_pkg::KEY_W+krt_pkg::TAG_W-1:krt_pkg::KEY_W];
	assign in_rec.amount = s_tdata[krt_pkg::IN_TDATA_W-1:krt_pkg::KEY_W+krt_pkg::TAG_W];

	krt_seq #(
		.CAPACITY (CAPACITY),
		.ADDR_W   (ADDR_W)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.in_op        (s_tuser),
		.in_rec       (in_rec),
		.out_free     (out_free),
		.emit         (emit),
		.fill         (fill),
		.mem_we       (mem_we),
		.mem_waddr    (mem_waddr),
		.mem_wdata    (mem_wdata),
		.mem_raddr    (mem_raddr),
		.mem_rdata    (mem_rdata),
		.div_start    (div_start),
		.div_dividend (div_dividend),
		.div_divisor  (div_divisor),
		.div_done     (div_done),
		.div_quot     (div_quot)
	);

	krt_mem #(
		.DEPTH  (CAPACITY),
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	krt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	// output register
	assign out_free = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= emit.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && emit.valid) begin
			out_q  <= emit;
			fill_q <= fill;
		end
	end

	// pack output word
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {1'b0, fill_q, out_q.rec.amount, out_q.rec.tag, out_q.rec.key};
	assign m_tuser  = out_q.status;
	assign m_tlast  = out_q.last;

endmodule

`default_nettype wire

### src/krt_check.sv
`default_nettype none

module krt_check #(
	parameter int CAPACITY = 64
) (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                s_tvalid,
	input wire logic                                s_tready,
	input wire logic [krt_pkg::IN_TDATA_W-1:0]      s_tdata,
	input wire logic [krt_pkg::OP_W-1:0]            s_tuser,
	input wire logic                                m_tvalid,
	input wire logic                                m_tready,
	input wire logic [krt_pkg::OUT_TDATA_W-1:0]     m_tdata,
	input wire logic [1:0]                          m_tuser,
	input wire logic                                m_tlast
);

	logic [krt_pkg::CNT_W-1:0] fill_w;

	assign fill_w = m_tdata[krt_pkg::IN_TDATA_W+krt_pkg::CNT_W-1:krt_pkg::IN_TDATA_W];

	// a stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed under stall");

	// full is only reported at capacity
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == krt_pkg::STAT_FULL)
		|-> (fill_w == krt_pkg::CNT_W'(CAPACITY)) && m_tlast)
		else $error("full status below capacity");

	// empty list reports an empty table
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == krt_pkg::STAT_EMPTY) |-> (fill_w == '0) && m_tlast)
		else $error("empty status with records held");

	// fill count never exceeds capacity
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> fill_w <= krt_pkg::CNT_W'(CAPACITY))
		else $error("fill count above capacity");

	// a miss carries a zero record
	a_miss: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == krt_pkg::STAT_NOT_FOUND)
		|-> (m_tdata[krt_pkg::IN_TDATA_W-1:0] == '0) && m_tlast)
		else $error("miss with record data");

endmodule

bind keyed_record_table_top krt_check #(.CAPACITY(CAPACITY)) u_check (.*);

`default_nettype wire

### bench/tb.sv
`timescale 1ns / 100ps

module tb;

	localparam int OP_W = krt_pkg::OP_W;
	localparam int KEY_W = krt_pkg::KEY_W;
	localparam int TAG_W = krt_pkg::TAG_W;
	localparam int AMT_W = krt_pkg::AMT_W;
	localparam int CNT_W = krt_pkg::CNT_W;
	localparam int IN_TDATA_W = krt_pkg::IN_TDATA_W;
	localparam int OUT_TDATA_W = krt_pkg::OUT_TDATA_W;
	localparam int TABLE_DEPTH = 64;
	localparam int RANDOM_ITEMS = 300;
	localparam int STALL_LIMIT = 4000;
	localparam int LONG_HOLD = 300;
	localparam int TAIL_CYCLES = 200;
	// opcodes the block answers without touching the table
	localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_LAST = 3'd7;

	typedef enum {PH_FILL, PH_CHURN, PH_DRAIN} phase_t;

	typedef struct {
		krt_pkg::status_t status;
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
		logic [AMT_W-1:0] amount;
		logic [CNT_W-1:0] fill;
		logic             last;
	} table_word_t;

	typedef struct {
		logic [OP_W-1:0]  op;
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
		logic [AMT_W-1:0] amount;
		bit               fixed;
		krt_pkg::status_t want_status;
		bit               want_echo;
		int               want_fill;
	} script_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	// record_key, name_tag, amount
	logic [IN_TDATA_W-1:0] s_tdata;
	// opcode
	logic [OP_W-1:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	// out_key, out_name_tag, out_amount, fill_count, zero pad
	logic [OUT_TDATA_W-1:0] m_tdata;
	// status
	logic [1:0] m_tuser;
	logic m_tlast;

	// shadow copy of the table
	logic [KEY_W-1:0] held_keys[TABLE_DEPTH];
	logic [TAG_W-1:0] held_tags[TABLE_DEPTH];
	logic [AMT_W-1:0] held_amounts[TABLE_DEPTH];
	int rows_held;

	table_word_t step_words[$];
	table_word_t pending_words[$];
	int bad_words = 0;
	int idle_cycles = 0;
	bit long_hold_req = 1'b0;
	bit tx_smooth = 1'b0;
	bit rx_smooth = 1'b0;

	// fixed rows carry a hand-written expectation, the rest go through the predictor
	script_row_t script[23] = '{
		'{krt_pkg::OP_LIST, 32'h0, 64'h0, 32'h0, 1'b1, krt_pkg::STAT_EMPTY, 1'b0, 0},
		'{krt_pkg::OP_AVERAGE, 32'h0, 64'h0, 32'h0, 1'b1, krt_pkg::STAT_DONE, 1'b0, 0},
		'{krt_pkg::OP_FIND, 32'h0, 64'h0, 32'h0, 1'b1, krt_pkg::STAT_NOT_FOUND, 1'b0, 0},
		'{krt_pkg::OP_DELETE, 32'h8000_0000, 64'h0, 32'h0, 1'b1,
			krt_pkg::STAT_NOT_FOUND, 1'b0, 0},
		'{OP_SPARE_FIRST, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF,
			1'b1, krt_pkg::STAT_DONE, 1'b0, 0},
		'{krt_pkg::OP_APPEND, 32'h8000_0000, 64'h0, 32'h0, 1'b1, krt_pkg::STAT_DONE,
			1'b1, 1},
		'{krt_pkg::OP_APPEND, 32'h7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF,
			1'b1, krt_pkg::STAT_DONE, 1'b1, 2},
		'{krt_pkg::OP_APPEND, 32'hFFFF_FFFF, 64'h0123_4567_89AB_CDEF, 32'd100,
			1'b0, krt_pkg::STAT_DONE, 1'b0, 0},
		'{krt_pkg::OP_APPEND, 32'h0, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA,
			1'b0, krt_pkg::STAT_DONE, 1'b0, 0},
		'{krt_pkg::OP_APPEND, 32'h7FFF_FFFF, 64'h1, 32'h1, 1'b0, krt_pkg::STAT_DONE,
			1'b0, 0},
		'{krt_pkg::OP_LIST, 32'h0, 64'h0, 32'h0, 1'b0, krt_pkg::STAT_DONE, 1'b0, 0},
		'{krt_pkg::OP_AVERAGE, 32'h0, 64'h0, 32'h0, 1'b0, krt_pkg::STAT_DONE, 1'b0, 0},
		'{krt_pkg::OP_FIND, 32'h7FFF_FFFF, 64'h0, 32'h0, 1'b0, krt_pkg::STAT_DONE,
			1'b0, 0},
		'{krt_pkg::OP_DELETE, 32'h7FFF_FFFF, 64'h0, 32'h0, 1'b0, krt_pkg::STAT_DONE,
			1'b0, 0},
		'{krt_pkg::OP_FIND, 32'h7FFF_FFFF, 64'h0, 32'h0, 1'b0, krt_pkg::STAT_DONE,
			1'b0, 0},
		'{krt_pkg::OP_DELETE, 32'h8000_0000, 64'h0, 32'h0, 1'b0, krt_pkg::STAT_DONE,
			1'b0, 0},
		'{krt_pkg::OP_FIND, 32'd1234, 64'h0, 32'h0, 1'b1, krt_pkg::STAT_NOT_FOUND,
			1'b0, 3},
		'{OP_SPARE_LAST, 32'hAAAA_AAAA, 64'h5555_5555_5555_5555, 32'h5555_5555,
			1'b1, krt_pkg::STAT_DONE, 1'b0, 3},
		'{OP_SPARE_LAST - 3'd1, 32'h0, 64'h0, 32'h0, 1'b1, krt_pkg::STAT_DONE, 1'b0, 3},
		'{krt_pkg::OP_LIST, 32'h0, 64'h0, 32'h0, 1'b0, krt_pkg::STAT_DONE, 1'b0, 0},
		'{krt_pkg::OP_DELETE, 32'h7FFF_FFFF, 64'h0, 32'h0, 1'b0, krt_pkg::STAT_DONE,
			1'b0, 0},
		'{krt_pkg::OP_AVERAGE, 32'h0, 64'h0, 32'h0, 1'b0, krt_pkg::STAT_DONE, 1'b0, 0},
		'{krt_pkg::OP_LIST, 32'h0, 64'h0, 32'h0, 1'b0, krt_pkg::STAT_DONE, 1'b0, 0}
	};

	keyed_record_table_top #(
		.CAPACITY(TABLE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always #1 clk = ~clk;

	// one result word, fill taken from the current row count
	function automatic table_word_t word_of(krt_pkg::status_t st, logic [KEY_W-1:0] k,
			logic [TAG_W-1:0] t, logic [AMT_W-1:0] a, logic l);
		table_word_t w;
		w.status = st;
		w.key = k;
		w.tag = t;
		w.amount = a;
		w.fill = CNT_W'(rows_held);
		w.last = l;
		return w;
	endfunction

	// apply one command to the shadow table, leave its words in step_words
	function automatic void table_step(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
			logic [TAG_W-1:0] tag, logic [AMT_W-1:0] amount);
		int hit;
		logic [63:0] total;
		logic [KEY_W-1:0] k;
		logic [TAG_W-1:0] t;
		logic [AMT_W-1:0] a;
		step_words = {};
		hit = -1;
		for (int i = 0; i < rows_held; i++)
			if (hit < 0 && held_keys[i] == key) hit = i;
		case (op)
			krt_pkg::OP_APPEND: begin
				if (rows_held >= TABLE_DEPTH) begin
					step_words.push_back(word_of(krt_pkg::STAT_FULL, '0, '0, '0, 1'b1));
				end else begin
					held_keys[rows_held] = key;
					held_tags[rows_held] = tag;
					held_amounts[rows_held] = amount;
					rows_held++;
					step_words.push_back(word_of(krt_pkg::STAT_DONE, key, tag, amount,
						1'b1));
				end
			end
			krt_pkg::OP_LIST: begin
				if (rows_held == 0)
					step_words.push_back(word_of(krt_pkg::STAT_EMPTY, '0, '0, '0, 1'b1));
				for (int i = 0; i < rows_held; i++)
					step_words.push_back(word_of(krt_pkg::STAT_DONE, held_keys[i],
						held_tags[i], held_amounts[i], i == rows_held - 1));
			end
			krt_pkg::OP_FIND, krt_pkg::OP_DELETE: begin
				if (hit < 0) begin
					step_words.push_back(word_of(krt_pkg::STAT_NOT_FOUND, '0, '0, '0,
						1'b1));
				end else begin
					k = held_keys[hit];
					t = held_tags[hit];
					a = held_amounts[hit];
					// delete closes the gap by moving later rows down
					if (op == krt_pkg::OP_DELETE) begin
						for (int j = hit; j < rows_held - 1; j++) begin
							held_keys[j] = held_keys[j + 1];
							held_tags[j] = held_tags[j + 1];
							held_amounts[j] = held_amounts[j + 1];
						end
						rows_held--;
					end
					step_words.push_back(word_of(krt_pkg::STAT_DONE, k, t, a, 1'b1));
				end
			end
			krt_pkg::OP_AVERAGE: begin
				total = '0;
				for (int i = 0; i < rows_held; i++) total += 64'(held_amounts[i]);
				a = (rows_held == 0) ? '0 : AMT_W'(total / 64'(rows_held));
				step_words.push_back(word_of(krt_pkg::STAT_DONE, '0, '0, a, 1'b1));
			end
			default: step_words.push_back(word_of(krt_pkg::STAT_DONE, '0, '0, '0, 1'b1));
		endcase
	endfunction

	// present one command, wait for its handshake, then predict it
	task automatic offer(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
			logic [TAG_W-1:0] tag, logic [AMT_W-1:0] amount);
		int roll;
		int gap;
		roll = $urandom_range(0, 99);
		gap = 0;
		if (!tx_smooth) begin
			if (roll >= 92) gap = $urandom_range(8, 40);
			else if (roll >= 60) gap = $urandom_range(1, 3);
		end
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {amount, tag, key};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		table_step(op, key, tag, amount);
	endtask

	task automatic check_field(string what, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %h got %h", $time, what, want, got);
			bad_words++;
		end
	endtask

	// compare each word taken on the result side with the oldest expectation
	always @(posedge clk) begin
		table_word_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_words.size() == 0) begin
				$display("%0t: unexpected word status %0d key %h", $time, m_tuser,
					m_tdata[KEY_W-1:0]);
				bad_words++;
			end else begin
				want = pending_words.pop_front();
				check_field("status", 64'(want.status), 64'(m_tuser));
				check_field("key", 64'(want.key), 64'(m_tdata[KEY_W-1:0]));
				check_field("tag", want.tag, m_tdata[KEY_W +: TAG_W]);
				check_field("amount", 64'(want.amount), 64'(m_tdata[KEY_W+TAG_W +: AMT_W]));
				check_field("fill", 64'(want.fill),
					64'(m_tdata[KEY_W+TAG_W+AMT_W +: CNT_W]));
				check_field("last", 64'(want.last), 64'(m_tlast));
			end
		end
	end

	// no progress on either side for too long ends the run
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// result side backpressure, with one long hold on request
	initial begin
		int hold_left;
		int roll;
		hold_left = 0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			roll = $urandom_range(0, 99);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (rx_smooth || roll < 65) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b0;
				hold_left = (roll >= 95) ? $urandom_range(10, 40) : $urandom_range(0, 3);
			end
		end
	end

	initial begin
		script_row_t row;
		table_word_t want;
		phase_t kind;
		logic [OP_W-1:0] op;
		logic [OP_W-1:0] spare;
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
		logic [AMT_W-1:0] amount;
		int roll;
		int steps;
		int overflow;
		int empty_probes;
		int sent_random;
		int phase;
		int hit_pct;
		bit hold_done;

		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		arst_n = 1'b0;
		rows_held = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed script
		foreach (script[i]) begin
			row = script[i];
			offer(row.op, row.key, row.tag, row.amount);
			if (row.fixed) begin
				want.status = row.want_status;
				want.key = row.want_echo ? row.key : '0;
				want.tag = row.want_echo ? row.tag : '0;
				want.amount = row.want_echo ? row.amount : '0;
				want.fill = CNT_W'(row.want_fill);
				want.last = 1'b1;
				pending_words.push_back(want);
			end else begin
				pending_words = {pending_words, step_words};
			end
		end

		// random phases: fill to overflow, churn, drain to empty, churn
		sent_random = 0;
		hold_done = 1'b0;
		for (phase = 0; sent_random < RANDOM_ITEMS; phase++) begin
			case (phase % 4)
				0: kind = PH_FILL;
				2: kind = PH_DRAIN;
				default: kind = PH_CHURN;
			endcase
			tx_smooth = ($urandom_range(0, 3) == 0);
			rx_smooth = ($urandom_range(0, 3) == 0);
			steps = 0;
			overflow = 0;
			empty_probes = 0;
			while (sent_random < RANDOM_ITEMS && steps < 150) begin
				if (kind == PH_FILL && overflow >= 3) break;
				if (kind == PH_DRAIN && empty_probes >= 2) break;
				if (kind == PH_CHURN && steps >= 25) break;
				spare = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
				roll = $urandom_range(0, 99);
				case (kind)
					PH_FILL: op = roll < 75 ? krt_pkg::OP_APPEND :
						roll < 82 ? krt_pkg::OP_FIND :
						roll < 87 ? krt_pkg::OP_LIST :
						roll < 92 ? krt_pkg::OP_AVERAGE :
						roll < 96 ? krt_pkg::OP_DELETE : spare;
					PH_DRAIN: op = roll < 65 ? krt_pkg::OP_DELETE :
						roll < 75 ? krt_pkg::OP_FIND :
						roll < 82 ? krt_pkg::OP_LIST :
						roll < 88 ? krt_pkg::OP_AVERAGE :
						roll < 93 ? krt_pkg::OP_APPEND : spare;
					default: op = roll < 20 ? krt_pkg::OP_APPEND :
						roll < 40 ? krt_pkg::OP_FIND :
						roll < 60 ? krt_pkg::OP_DELETE :
						roll < 75 ? krt_pkg::OP_LIST :
						roll < 95 ? krt_pkg::OP_AVERAGE : spare;
				endcase
				if (op == krt_pkg::OP_APPEND && rows_held >= TABLE_DEPTH) overflow++;
				if (kind == PH_DRAIN && rows_held == 0) empty_probes++;

				// keys: mostly ones held, else a small pool for duplicates, else anything
				hit_pct = (kind == PH_DRAIN) ? 90 : 55;
				roll = $urandom_range(0, 99);
				if (op != krt_pkg::OP_APPEND && rows_held > 0 && roll < hit_pct)
					key = held_keys[$urandom_range(0, rows_held - 1)];
				else if (roll % 3 == 0)
					key = KEY_W'($urandom_range(0, 15)) - KEY_W'(8);
				else
					key = $urandom;
				roll = $urandom_range(0, 19);
				tag = (roll == 0) ? {TAG_W{1'b0}} : (roll == 1) ? {TAG_W{1'b1}} :
					{$urandom, $urandom};
				roll = $urandom_range(0, 9);
				amount = (roll == 0) ? {AMT_W{1'b0}} : (roll == 1) ? {AMT_W{1'b1}} :
					AMT_W'($urandom);

				// stall the result side once while commands keep coming
				if (!hold_done && kind == PH_FILL && rows_held >= 20) begin
					long_hold_req = 1'b1;
					hold_done = 1'b1;
				end

				offer(op, key, tag, amount);
				pending_words = {pending_words, step_words};
				steps++;
				if (op <= krt_pkg::OP_AVERAGE) sent_random++;
			end

			// sometimes let every result drain before the next phase
			if (phase == 0 || $urandom_range(0, 1) == 1) begin
				while (pending_words.size() != 0) begin
					s_tvalid <= 1'b0;
					@(posedge clk);
				end
			end
		end

		// drain and let the block settle
		while (pending_words.size() != 0) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b0;
		repeat (TAIL_CYCLES) @(posedge clk);
		if (bad_words == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
